### hdl/aes_cf_pkg.sv
package aes_cf_pkg;

	localparam int unsigned Rounds = 10;
	localparam logic [7:0] FieldLow = 8'hE7;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] blk_t;

	// register indices, decoded from paddr[4:3]
	typedef enum logic [1:0] {
		REG_KEY_HIGH = 2'd0,
		REG_KEY_LOW  = 2'd1,
		REG_MODE     = 2'd2
	} reg_idx_t;

	// round key schedule handed down the chain
	typedef struct packed {
		logic [Rounds:0][127:0] rk;
	} sched_t;

	function automatic byte_t gmul(input byte_t a, input byte_t b);
		logic [7:0] x;
		logic [7:0] r;
		x = a;
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x;
			x = x[7] ? ({x[6:0], 1'b0} ^ FieldLow) : {x[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic byte_t ginv(input byte_t a);
		byte_t r;
		byte_t b;
		r = 8'd1;
		b = a;
		for (int i = 0; i < 8; i++) begin
			if (i != 0) r = gmul(r, b);
			b = gmul(b, b);
		end
		return r;
	endfunction

	function automatic byte_t rotl(input byte_t x, input int n);
		return byte_t'((x << n) | (x >> (8 - n)));
	endfunction

	function automatic byte_t sbox_f(input byte_t x);
		byte_t b;
		b = ginv(x);
		return b ^ rotl(b, 1) ^ rotl(b, 2) ^ rotl(b, 3) ^ rotl(b, 4) ^ 8'h63;
	endfunction

	function automatic byte_t isbox_f(input byte_t x);
		return ginv(rotl(x, 1) ^ rotl(x, 3) ^ rotl(x, 6) ^ 8'h05);
	endfunction

	typedef byte_t [255:0] lut_t;

	function automatic lut_t mk_sbox();
		lut_t t;
		for (int i = 0; i < 256; i++) t[i] = sbox_f(byte_t'(i));
		return t;
	endfunction

	function automatic lut_t mk_isbox();
		lut_t t;
		for (int i = 0; i < 256; i++) t[i] = isbox_f(byte_t'(i));
		return t;
	endfunction

	localparam lut_t Sbox = mk_sbox();
	localparam lut_t InvSbox = mk_isbox();

	localparam byte_t [9:0] Rcon = '{8'h29, 8'hE7, 8'h80, 8'h40, 8'h20,
		8'h10, 8'h08, 8'h04, 8'h02, 8'h01};

	// byte n of a block: file order, byte 0 in the top bits
	function automatic byte_t bget(input blk_t s, input int n);
		return s[127 - 8 * n -: 8];
	endfunction

	function automatic blk_t next_key(input blk_t p, input byte_t rc);
		blk_t q;
		byte_t t [4];
		for (int i = 0; i < 4; i++) t[i] = Sbox[bget(p, 12 + ((i + 1) % 4))];
		t[0] = t[0] ^ rc;
		for (int i = 0; i < 4; i++) q[127 - 8 * i -: 8] = bget(p, i) ^ t[i];
		for (int i = 4; i < 16; i++)
			q[127 - 8 * i -: 8] = bget(p, i) ^ q[127 - 8 * (i - 4) -: 8];
		return q;
	endfunction

endpackage

### hdl/aes_cf_round.sv
// one round cell: encrypt or decrypt round on the passing block
module aes_cf_round #(
	parameter int unsigned Idx = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               vld_in,
	input  logic               dec_in,
	input  aes_cf_pkg::blk_t   st_in,
	input  aes_cf_pkg::sched_t ks_in,
	output logic               vld_q,
	output logic               dec_q,
	output aes_cf_pkg::blk_t   st_q,
	output aes_cf_pkg::sched_t ks_q
);

	localparam int unsigned Last = aes_cf_pkg::Rounds;

	aes_cf_pkg::blk_t enc_d, dec_d, sb, sr, isr, isb, ak;
	aes_cf_pkg::byte_t o0, o1, o2, o3;

	// encrypt path: subbytes, shiftrows, mixcolumns (not in the last round), addroundkey
	always_comb begin
		o0 = '0;
		o1 = '0;
		o2 = '0;
		o3 = '0;
		for (int i = 0; i < 16; i++)
			sb[127 - 8 * i -: 8] = aes_cf_pkg::Sbox[aes_cf_pkg::bget(st_in, i)];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				sr[127 - 8 * (4 * c + r) -: 8] = aes_cf_pkg::bget(sb, 4 * ((c + r) % 4) + r);
		enc_d = sr;
		if (Idx != Last) begin
			for (int c = 0; c < 4; c++) begin
				o0 = aes_cf_pkg::bget(sr, 4 * c);
				o1 = aes_cf_pkg::bget(sr, 4 * c + 1);
				o2 = aes_cf_pkg::bget(sr, 4 * c + 2);
				o3 = aes_cf_pkg::bget(sr, 4 * c + 3);
				enc_d[127 - 8 * (4 * c) -: 8] = aes_cf_pkg::gmul(8'd2, o0)
					^ aes_cf_pkg::gmul(8'd3, o1) ^ o2 ^ o3;
				enc_d[127 - 8 * (4 * c + 1) -: 8] = o0 ^ aes_cf_pkg::gmul(8'd2, o1)
					^ aes_cf_pkg::gmul(8'd3, o2) ^ o3;
				enc_d[127 - 8 * (4 * c + 2) -: 8] = o0 ^ o1
					^ aes_cf_pkg::gmul(8'd2, o2) ^ aes_cf_pkg::gmul(8'd3, o3);
				enc_d[127 - 8 * (4 * c + 3) -: 8] = aes_cf_pkg::gmul(8'd3, o0) ^ o1 ^ o2
					^ aes_cf_pkg::gmul(8'd2, o3);
			end
		end
		enc_d = enc_d ^ ks_in.rk[Idx];
	end

	// decrypt path: inverse shiftrows, inverse subbytes, addroundkey, inverse mix (not in the last round)
	always_comb begin
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				isr[127 - 8 * (4 * ((c + r) % 4) + r) -: 8] = aes_cf_pkg::bget(st_in, 4 * c + r);
		for (int i = 0; i < 16; i++)
			isb[127 - 8 * i -: 8] = aes_cf_pkg::InvSbox[aes_cf_pkg::bget(isr, i)];
		ak = isb ^ ks_in.rk[Last - Idx];
		dec_d = ak;
		if (Idx != Last) begin
			for (int c = 0; c < 4; c++)
				for (int j = 0; j < 4; j++)
					dec_d[127 - 8 * (4 * c + j) -: 8] =
						aes_cf_pkg::gmul(8'd14, aes_cf_pkg::bget(ak, 4 * c + j))
						^ aes_cf_pkg::gmul(8'd11, aes_cf_pkg::bget(ak, 4 * c + (j + 1) % 4))
						^ aes_cf_pkg::gmul(8'd13, aes_cf_pkg::bget(ak, 4 * c + (j + 2) % 4))
						^ aes_cf_pkg::gmul(8'd9, aes_cf_pkg::bget(ak, 4 * c + (j + 3) % 4));
		end
	end

	// control of the cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (adv) begin
			vld_q <= vld_in;
		end
	end

	// payload of the cell
	always_ff @(posedge clk) begin
		if (adv) begin
			dec_q <= dec_in;
			st_q  <= dec_in ? dec_d : enc_d;
			ks_q  <= ks_in;
		end
	end

endmodule

### hdl/aes128_custom_field_cipher.sv
// a result is valid once its request has passed the input stage, ten round cells and
// the output register; throughput: one block per cycle while the chain does not stall
// the whole chain stalls only when the output register is full and not taken
// key schedule ripples through eleven registers; requests are held off after reset
// and after every register write while it settles
// reset: asynchronous, clears valid flags, the key and mode registers and the schedule
module aes128_custom_field_cipher (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [127:0]  s_tdata,  // block_high [63:0], block_low [127:64]
	output logic          m_tvalid,
	input  logic          m_tready,
	output logic [127:0]  m_tdata   // out_high [63:0], out_low [127:64]
);

	localparam int unsigned N = aes_cf_pkg::Rounds;
	localparam logic [3:0] KsWait = 4'(N + 1);

	logic [63:0] key_high_q, key_low_q;
	logic        mode_q;
	logic        wr;
	aes_cf_pkg::sched_t ks_q;
	logic [3:0]  ks_wait_q;

	// register file
	assign pready = 1'b1;
	assign wr = psel & penable & pwrite;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
			mode_q     <= 1'b0;
		end else if (wr) begin
			unique case (paddr[4:3])
				aes_cf_pkg::REG_KEY_HIGH: key_high_q <= pwdata;
				aes_cf_pkg::REG_KEY_LOW:  key_low_q <= pwdata;
				aes_cf_pkg::REG_MODE:     mode_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			aes_cf_pkg::REG_KEY_HIGH: prdata = key_high_q;
			aes_cf_pkg::REG_KEY_LOW:  prdata = key_low_q;
			aes_cf_pkg::REG_MODE:     prdata = {63'd0, mode_q};
			default:                  prdata = '0;
		endcase
	end

	// key schedule registers, one round key each, ripple from the key
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_q <= '0;
		end else begin
			ks_q.rk[0] <= {key_high_q, key_low_q};
			for (int r = 1; r <= N; r++)
				ks_q.rk[r] <= aes_cf_pkg::next_key(ks_q.rk[r - 1], aes_cf_pkg::Rcon[r - 1]);
		end
	end

	// hold off requests until the schedule has settled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ks_wait_q <= KsWait;
		end else if (wr) begin
			ks_wait_q <= KsWait;
		end else if (ks_wait_q != '0) begin
			ks_wait_q <= ks_wait_q - 4'd1;
		end
	end

	// input stage: initial addroundkey
	logic adv;
	logic vld_s1, dec_s1;
	aes_cf_pkg::blk_t st_s1, in_blk;
	assign in_blk = {s_tdata[63:0], s_tdata[127:64]};

	logic [N:0]              vld_c;
	logic [N:0]              dec_c;
	aes_cf_pkg::blk_t [N:0]  st_c;
	aes_cf_pkg::sched_t [N:0] ks_c;

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv && (ks_wait_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dec_s1 <= mode_q;
			st_s1  <= in_blk ^ (mode_q ? ks_q.rk[N] : ks_q.rk[0]);
		end
	end

	assign vld_c[0] = vld_s1;
	assign dec_c[0] = dec_s1;
	assign st_c[0]  = st_s1;
	assign ks_c[0]  = ks_q;

	// chain of round cells
	for (genvar g = 1; g <= N; g++) begin : g_cell
		aes_cf_round #(.Idx(g)) u_round (
			.clk(clk), .arst_n(arst_n), .adv(adv),
			.vld_in(vld_c[g - 1]), .dec_in(dec_c[g - 1]),
			.st_in(st_c[g - 1]), .ks_in(ks_c[g - 1]),
			.vld_q(vld_c[g]), .dec_q(dec_c[g]),
			.st_q(st_c[g]), .ks_q(ks_c[g])
		);
	end

	// output register
	logic out_vld_q;
	aes_cf_pkg::blk_t out_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_c[N];
		end
	end
	always_ff @(posedge clk) begin
		if (adv) out_q <= st_c[N];
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {out_q[63:0], out_q[127:64]};

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid && ks_wait_q == '0 |-> s_tready)
		else $error("input stalled with empty output");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> dec_s1 == $past(mode_q))
		else $error("mode not captured");
`endif

endmodule

### sim/testbench.sv
module testbench;

	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned Settle = 40;

	// ---------------------------------------------------------------
	// cipher predictor over the 0x1e7 field
	// ---------------------------------------------------------------
	function automatic logic [7:0] fmul(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] x;
		logic [7:0] r;
		x = {1'b0, a};
		r = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) r = r ^ x[7:0];
			x = x << 1;
			if (x[8]) x = {1'b0, x[7:0] ^ 8'hE7};
		end
		return r;
	endfunction

	function automatic logic [7:0] finv(input logic [7:0] a);
		logic [7:0] r;
		logic [7:0] p;
		int e;
		r = 8'd1;
		p = a;
		e = 254;
		while (e != 0) begin
			if (e & 1) r = fmul(r, p);
			p = fmul(p, p);
			e = e >> 1;
		end
		return r;
	endfunction

	function automatic logic [7:0] rol8(input logic [7:0] x, input int n);
		return (x << n) | (x >> (8 - n));
	endfunction

	function automatic logic [7:0] subst(input logic [7:0] x);
		logic [7:0] b;
		b = finv(x);
		return b ^ rol8(b, 1) ^ rol8(b, 2) ^ rol8(b, 3) ^ rol8(b, 4) ^ 8'h63;
	endfunction

	function automatic logic [7:0] inv_subst(input logic [7:0] x);
		return finv(rol8(x, 1) ^ rol8(x, 3) ^ rol8(x, 6) ^ 8'h05);
	endfunction

	logic [63:0] cfg_key_hi;
	logic [63:0] cfg_key_lo;
	logic        cfg_decrypt;

	// returns {hi, lo}; byte n sits at bits 127-8n
	function automatic logic [127:0] cipher_block(input logic [127:0] blk);
		logic [7:0] rk [11][16];
		logic [7:0] st [16];
		logic [7:0] o [16];
		logic [7:0] t [4];
		logic [7:0] v;
		logic [7:0] rc [10];
		logic [7:0] mf [4];
		logic [7:0] mb [4];
		logic [127:0] kk;
		logic [127:0] res;
		rc = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'hE7, 8'h29};
		mf = '{8'd2, 8'd3, 8'd1, 8'd1};
		mb = '{8'd14, 8'd11, 8'd13, 8'd9};
		kk = {cfg_key_hi, cfg_key_lo};
		for (int i = 0; i < 16; i++) begin
			rk[0][i] = kk[127 - 8 * i -: 8];
			st[i] = blk[127 - 8 * i -: 8];
		end
		// key expansion
		for (int r = 1; r <= 10; r++) begin
			for (int i = 0; i < 4; i++) t[i] = subst(rk[r - 1][12 + ((i + 1) & 3)]);
			t[0] = t[0] ^ rc[r - 1];
			for (int i = 0; i < 4; i++) rk[r][i] = rk[r - 1][i] ^ t[i];
			for (int i = 4; i < 16; i++) rk[r][i] = rk[r - 1][i] ^ rk[r][i - 4];
		end
		if (cfg_decrypt) begin
			for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[10][i];
			for (int r = 9; r >= 0; r--) begin
				o = st;
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++) st[4 * ((c + w) & 3) + w] = o[4 * c + w];
				for (int i = 0; i < 16; i++) st[i] = inv_subst(st[i]) ^ rk[r][i];
				if (r != 0) begin
					o = st;
					for (int c = 0; c < 4; c++)
						for (int j = 0; j < 4; j++) begin
							v = '0;
							for (int k = 0; k < 4; k++) v = v ^ fmul(mb[(k - j) & 3], o[4 * c + k]);
							st[4 * c + j] = v;
						end
				end
			end
		end else begin
			for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[0][i];
			for (int r = 1; r <= 10; r++) begin
				for (int i = 0; i < 16; i++) o[i] = subst(st[i]);
				for (int c = 0; c < 4; c++)
					for (int w = 0; w < 4; w++) st[4 * c + w] = o[4 * ((c + w) & 3) + w];
				if (r != 10) begin
					o = st;
					for (int c = 0; c < 4; c++)
						for (int j = 0; j < 4; j++) begin
							v = '0;
							for (int k = 0; k < 4; k++) v = v ^ fmul(mf[(k - j) & 3], o[4 * c + k]);
							st[4 * c + j] = v;
						end
				end
				for (int i = 0; i < 16; i++) st[i] = st[i] ^ rk[r][i];
			end
		end
		for (int i = 0; i < 16; i++) res[127 - 8 * i -: 8] = st[i];
		return res;
	endfunction

	// ---------------------------------------------------------------
	// scoreboard of pending cipher outputs
	// ---------------------------------------------------------------
	class cipher_scoreboard;
		logic [127:0] pending [$];
		int errors;

		function new();
			errors = 0;
		endfunction

		function void note_request(input logic [127:0] want);
			pending.push_back(want);
		endfunction

		function void check_output(input logic [127:0] got, input logic [63:0] now);
			logic [127:0] want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected output hi=%h lo=%h", now, got[127:64], got[63:0]);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (want[127:64] !== got[127:64]) begin
				$display("%0t: out_high expected %h actual %h", now, want[127:64], got[127:64]);
				errors++;
			end
			if (want[63:0] !== got[63:0]) begin
				$display("%0t: out_low expected %h actual %h", now, want[63:0], got[63:0]);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          psel;
	logic          penable;
	logic          pwrite;
	logic [4:0]    paddr;
	logic [63:0]   pwdata;
	logic [63:0]   prdata;
	logic          pready;
	logic          s_tvalid;
	logic          s_tready;
	logic [127:0]  s_tdata;
	logic          m_tvalid;
	logic          m_tready;
	logic [127:0]  m_tdata;

	aes128_custom_field_cipher u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	cipher_scoreboard sb = new();
	int unsigned cycles;
	int unsigned stall_style;

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// request and output monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			sb.note_request(cipher_block({s_tdata[63:0], s_tdata[127:64]}));
		if (arst_n && m_tvalid && m_tready)
			sb.check_output({m_tdata[63:0], m_tdata[127:64]}, $time);
	end

	// receiver stall pattern
	always @(posedge clk) begin
		case (stall_style)
			0: m_tready <= 1'b1;
			1: m_tready <= (cycles % 13) < 9;
			2: m_tready <= $urandom_range(0, 3) != 0;
			default: m_tready <= $urandom_range(0, 4) == 0;
		endcase
	end

	task automatic reg_write(input aes_cf_pkg::reg_idx_t idx, input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(8 * int'(idx));
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			aes_cf_pkg::REG_KEY_HIGH: cfg_key_hi = val;
			aes_cf_pkg::REG_KEY_LOW:  cfg_key_lo = val;
			aes_cf_pkg::REG_MODE:     cfg_decrypt = val[0];
			default: ;
		endcase
	endtask

	// write to an address past the register list; must change nothing
	task automatic stray_write(input logic [63:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'd24;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// present one block and hold it until taken
	task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
		s_tvalid <= 1'b1;
		s_tdata <= {lo, hi};
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (Settle) @(posedge clk);
	endtask

	function automatic logic [63:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'h1 << $urandom_range(0, 63);
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_run(input int n, input bit gapless, input int pause_at);
		int left;
		int burst;
		left = n;
		while (left > 0) begin
			burst = $urandom_range(1, 24);
			while (burst > 0 && left > 0) begin
				send_block(rand_word(), rand_word());
				burst--;
				left--;
				if (left == pause_at) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (sb.pending.size() != 0) @(posedge clk);
				end
			end
			if (!gapless) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		cycles = 0;
		stall_style = 0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b1;
		cfg_key_hi = '0;
		cfg_key_lo = '0;
		cfg_decrypt = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (Settle) @(posedge clk);

		// directed: reset key, field extremes
		send_block('0, '0);
		send_block('1, '1);
		send_block(64'h8000000000000000, 64'h0000000000000001);
		send_block(64'h0123456789ABCDEF, 64'hFEDCBA9876543210);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();

		// directed: all-ones key, both directions
		reg_write(aes_cf_pkg::REG_KEY_HIGH, '1);
		reg_write(aes_cf_pkg::REG_KEY_LOW, '1);
		repeat (Settle) @(posedge clk);
		send_block('0, '0);
		send_block('1, '1);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		// mode bits above bit 0 are dropped
		reg_write(aes_cf_pkg::REG_MODE, 64'hFFFFFFFFFFFFFFFF);
		repeat (Settle) @(posedge clk);
		send_block('0, '0);
		send_block('1, '1);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();
		reg_write(aes_cf_pkg::REG_MODE, 64'hFFFFFFFFFFFFFFFE);
		stray_write('1);
		repeat (Settle) @(posedge clk);
		send_block(64'hA5A5A5A5A5A5A5A5, 64'h5A5A5A5A5A5A5A5A);
		s_tvalid <= 1'b0;
		@(posedge clk);
		drain();

		// random phases through several keys and both directions
		for (int ph = 0; ph < 8; ph++) begin
			stall_style = ph % 4;
			case (ph)
				0: begin
					reg_write(aes_cf_pkg::REG_KEY_HIGH, '0);
					reg_write(aes_cf_pkg::REG_KEY_LOW, '0);
				end
				1: begin
					reg_write(aes_cf_pkg::REG_KEY_HIGH, '1);
					reg_write(aes_cf_pkg::REG_KEY_LOW, '1);
				end
				default: begin
					reg_write(aes_cf_pkg::REG_KEY_HIGH, {$urandom, $urandom});
					reg_write(aes_cf_pkg::REG_KEY_LOW, {$urandom, $urandom});
				end
			endcase
			reg_write(aes_cf_pkg::REG_MODE, {$urandom, 31'd0, 1'(ph % 2)});
			repeat (Settle) @(posedge clk);
			random_run(236, ph == 2 || ph == 5, ph == 3 ? 120 : -1);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

### files.f
hdl/aes_cf_pkg.sv
hdl/aes_cf_round.sv
hdl/aes128_custom_field_cipher.sv
sim/testbench.sv
